>>> rtl/dcmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcmd_pkg
// Shared types, opcodes and sizes of the digital potentiometer command engine.
// ----------------------------------------------------------------------------
package dcmd_pkg;

  localparam int WIPER_BITS  = 10;
  localparam int STORE_DEPTH = 16;
  localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int TYPE_BITS   = 4;
  localparam int ADDRESS_BITS = 4;
  localparam int DATA_BITS   = 16;
  localparam int LOGIC_BITS  = 2;
  localparam int WPOS_BITS   = 10;

  localparam int S_TDATA_BITS = 24;
  localparam int M_TDATA_BITS = 32;

  localparam logic [WIPER_BITS-1:0] WIPER_FULL = {WIPER_BITS{1'b1}};
  localparam logic [WIPER_BITS-1:0] WIPER_MID  = WIPER_BITS'(1) << (WIPER_BITS - 1);

  typedef enum logic [TYPE_BITS-1:0] {
    OP_NOP         = 4'h0,
    OP_STORE       = 4'h2,
    OP_WRITE_ENTRY = 4'h3,
    OP_SHR         = 4'h4,
    OP_DEC         = 4'h6,
    OP_RESTORE     = 4'h8,
    OP_READ_ENTRY  = 4'h9,
    OP_READ_WIPER  = 4'hA,
    OP_WRITE       = 4'hB,
    OP_SHL         = 4'hC,
    OP_INC         = 4'hE
  } opcode_t;

  typedef struct packed {
    logic [TYPE_BITS-1:0]    req_type;
    logic [ADDRESS_BITS-1:0] address;
    logic [DATA_BITS-1:0]    data;
  } cmd_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]  read_data;
    logic [WPOS_BITS-1:0]  wiper_position;
    logic [LOGIC_BITS-1:0] logic_out;
  } result_t;

endpackage : dcmd_pkg
`default_nettype wire

>>> rtl/digipot_command_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// digipot_command_engine_top
// Chip-side command engine of a digital potentiometer with nonvolatile store.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one 24-bit command frame per transaction. The
//   master stream returns one result per frame: the read data asked for by
//   the previous frame (zero if it was not a read), the wiper setting and the
//   two logic outputs after this frame.
//   A frame passes through the input register, then the command executes and
//   its result is registered. Throughput is one frame per cycle unless the
//   receiver stalls; the wiper and store update in the same cycle the result
//   is registered, so the next frame sees them at once.
//   When the receiver stalls, the result register holds and the input
//   register fills; s_tready falls only once both are occupied.
//   Reset sets the wiper to midscale, clears the store, the logic bits and the
//   pending read, and empties both registers.
// ----------------------------------------------------------------------------
module digipot_command_engine_top import dcmd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [3:0] req_type, [7:4] address, [23:8] data
  input  wire logic [23:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [15:0] read_data, [25:16] wiper_position, [27:26] logic_out, [31:28] zero
  output logic [31:0]      m_tdata
);

  logic    cmd_valid;
  cmd_t    cmd;
  logic    out_free;
  logic    fire;
  result_t result;

  assign fire = cmd_valid && out_free;

  dcmd_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .take      (fire),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  dcmd_exec u_exec (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .cmd    (cmd),
    .result (result)
  );

  dcmd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd_valid),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule : digipot_command_engine_top
`default_nettype wire

>>> rtl/dcmd_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcmd_in_stage
// Input register: captures one command frame and holds it until executed.
// ----------------------------------------------------------------------------
module dcmd_in_stage import dcmd_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [S_TDATA_BITS-1:0] s_tdata,
  input  wire logic                    take,
  output logic                         cmd_valid,
  output cmd_t                         cmd
);

  assign s_tready = !cmd_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tready) begin
      cmd_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd.req_type <= s_tdata[3:0];
      cmd.address  <= s_tdata[7:4];
      cmd.data     <= s_tdata[23:8];
    end
  end

endmodule : dcmd_in_stage
`default_nettype wire

>>> rtl/dcmd_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcmd_exec
// Chip state (wiper, nonvolatile store, logic bits, pending read) and the
// single-pass command decode that updates it and forms the frame result.
// ----------------------------------------------------------------------------
module dcmd_exec import dcmd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fire,
  input  wire cmd_t cmd,
  output result_t   result
);

  logic [WIPER_BITS-1:0] wiper, wiper_next;
  logic [DATA_BITS-1:0]  nv_store [STORE_DEPTH];
  logic [LOGIC_BITS-1:0] logic_bits, logic_bits_next;
  logic [DATA_BITS-1:0]  pending_read, pending_read_next;

  logic [ADDR_BITS-1:0]  idx;
  logic                  addr_ok;
  logic                  nv_we;
  logic [ADDR_BITS-1:0]  nv_waddr;
  logic [DATA_BITS-1:0]  nv_wdata;
  logic [WIPER_BITS:0]   shl_val;

  assign idx     = ADDR_BITS'(cmd.address);
  assign addr_ok = (32'(cmd.address) < STORE_DEPTH);
  assign shl_val = {wiper, 1'b0};

  always_comb begin
    wiper_next        = wiper;
    logic_bits_next   = logic_bits;
    pending_read_next = '0;
    nv_we             = 1'b0;
    nv_waddr          = '0;
    nv_wdata          = cmd.data;
    unique case (opcode_t'(cmd.req_type))
      OP_STORE: begin
        nv_we    = 1'b1;
        nv_wdata = DATA_BITS'(wiper);
      end
      OP_WRITE_ENTRY: begin
        nv_we    = addr_ok;
        nv_waddr = idx;
      end
      OP_SHR: wiper_next = wiper >> 1;
      OP_DEC: begin
        if (wiper != '0) wiper_next = wiper - WIPER_BITS'(1);
      end
      OP_RESTORE: begin
        wiper_next      = WIPER_BITS'(nv_store[0]);
        logic_bits_next = nv_store[1][LOGIC_BITS-1:0];
      end
      OP_READ_ENTRY: begin
        if (addr_ok) pending_read_next = nv_store[idx];
      end
      OP_READ_WIPER: pending_read_next = DATA_BITS'(wiper);
      OP_WRITE: wiper_next = cmd.data[WIPER_BITS-1:0];
      OP_SHL: begin
        // A carry out of the top bit means the doubled value is past full scale.
        wiper_next = shl_val[WIPER_BITS] ? WIPER_FULL : shl_val[WIPER_BITS-1:0];
      end
      OP_INC: begin
        if (wiper != WIPER_FULL) wiper_next = wiper + WIPER_BITS'(1);
      end
      default: ;
    endcase
  end

  // The result carries the read data requested by the previous frame.
  always_comb begin
    result.read_data      = pending_read;
    result.wiper_position = WPOS_BITS'(wiper_next);
    result.logic_out      = logic_bits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wiper        <= WIPER_MID;
      logic_bits   <= '0;
      pending_read <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) nv_store[i] <= '0;
    end else if (fire) begin
      wiper        <= wiper_next;
      logic_bits   <= logic_bits_next;
      pending_read <= pending_read_next;
      if (nv_we) nv_store[nv_waddr] <= nv_wdata;
    end
  end

endmodule : dcmd_exec
`default_nettype wire

>>> rtl/dcmd_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcmd_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module dcmd_out_stage import dcmd_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  wire result_t                 result,
  output logic                         free,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [M_TDATA_BITS-1:0]      m_tdata
);

  result_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) held <= result;
  end

  assign m_tdata = {4'b0, held.logic_out, held.wiper_position, held.read_data};

endmodule : dcmd_out_stage
`default_nettype wire

>>> rtl/dcmd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcmd_checker
// Port-level checks of the command engine, bound to the top level.
// ----------------------------------------------------------------------------
module dcmd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // A stalled result must hold until the receiver takes it.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // After reset both registers are empty.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

  // The padding bits above the logic outputs are always zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:28] == 4'b0)
    else $error("nonzero padding in result");

  // With the receiver always ready, the input side can never be blocked.
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    m_tready && $past(m_tready) |-> s_tready)
    else $error("input blocked while output drains");

endmodule : dcmd_checker

bind digipot_command_engine_top dcmd_checker u_dcmd_checker (.*);
`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the digital potentiometer command engine. Command
// frames go in on the slave stream with random gaps. A local model of the
// wiper, the nonvolatile store, the logic bits and the pending read predicts
// each result. Every result on the master stream is checked field by field
// against the oldest prediction while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb;
  import dcmd_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_CYCLES  = 200;

  // Opcodes that the engine treats as no operation.
  localparam logic [3:0] OP_RSVD_1 = 4'h1;
  localparam logic [3:0] OP_RSVD_5 = 4'h5;
  localparam logic [3:0] OP_RSVD_7 = 4'h7;
  localparam logic [3:0] OP_RSVD_D = 4'hD;
  localparam logic [3:0] OP_RSVD_F = 4'hF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  // Model state of the potentiometer.
  logic [WIPER_BITS-1:0] pot_wiper;
  logic [15:0]           pot_store [STORE_DEPTH];
  logic [1:0]            pot_logic;
  logic [15:0]           pot_pending;

  result_t expected_frames [$];
  int      err_count = 0;
  bit      no_idle = 1'b0;
  bit      hold_results = 1'b0;

  digipot_command_engine_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  function automatic void reset_pot_model();
    pot_wiper   = WIPER_MID;
    pot_logic   = '0;
    pot_pending = '0;
    for (int i = 0; i < STORE_DEPTH; i++) pot_store[i] = '0;
  endfunction

  // Executes one command frame on the model and returns the frame it yields.
  function automatic result_t apply_command(logic [3:0] op, logic [3:0] addr,
                                            logic [15:0] data);
    result_t             res;
    logic [15:0]         next_read;
    logic [WIPER_BITS:0] doubled;
    next_read = '0;
    res.read_data = pot_pending;
    case (op)
      OP_STORE: pot_store[0] = 16'(pot_wiper);
      OP_WRITE_ENTRY: if (addr < STORE_DEPTH) pot_store[addr] = data;
      OP_SHR: pot_wiper = pot_wiper >> 1;
      OP_DEC: if (pot_wiper != '0) pot_wiper = pot_wiper - 1'b1;
      OP_RESTORE: begin
        pot_wiper = pot_store[0][WIPER_BITS-1:0];
        pot_logic = pot_store[1][1:0];
      end
      OP_READ_ENTRY: if (addr < STORE_DEPTH) next_read = pot_store[addr];
      OP_READ_WIPER: next_read = 16'(pot_wiper);
      OP_WRITE: pot_wiper = data[WIPER_BITS-1:0];
      OP_SHL: begin
        doubled = {1'b0, pot_wiper} << 1;
        pot_wiper = (doubled > WIPER_FULL) ? WIPER_FULL : doubled[WIPER_BITS-1:0];
      end
      OP_INC: if (pot_wiper != WIPER_FULL) pot_wiper = pot_wiper + 1'b1;
      default: ;
    endcase
    pot_pending = next_read;
    res.wiper_position = WPOS_BITS'(pot_wiper);
    res.logic_out = pot_logic;
    return res;
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long pause.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_command(logic [3:0] op, logic [3:0] addr, logic [15:0] data);
    int gap;
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {data, addr, op};
    do @(posedge clk); while (!s_tready);
    expected_frames.push_back(apply_command(op, addr, data));
  endtask

  // Receiver side: random stalls, or one long hold-off on request.
  initial begin
    int n;
    forever begin
      if (hold_results) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else if (no_idle) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.read_data      = m_tdata[15:0];
      got.wiper_position = m_tdata[25:16];
      got.logic_out      = m_tdata[27:26];
      if (expected_frames.size() == 0) begin
        $error("unexpected result transaction, tdata %h", m_tdata);
        err_count++;
      end else begin
        want = expected_frames.pop_front();
        if (got.read_data !== want.read_data) begin
          $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
          err_count++;
        end
        if (got.wiper_position !== want.wiper_position) begin
          $error("wiper_position: expected %0d, actual %0d",
                 want.wiper_position, got.wiper_position);
          err_count++;
        end
        if (got.logic_out !== want.logic_out) begin
          $error("logic_out: expected %b, actual %b", want.logic_out, got.logic_out);
          err_count++;
        end
      end
    end
  end

  task automatic test_reset_values();
    send_command(OP_READ_WIPER, 4'h0, 16'h0000);
    send_command(OP_READ_ENTRY, 4'hF, 16'hFFFF);
    send_command(OP_NOP, 4'h0, 16'h0000);
  endtask

  task automatic test_saturation();
    send_command(OP_WRITE, 4'h0, 16'hFFFF);
    send_command(OP_INC, 4'h0, 16'h0000);
    send_command(OP_SHL, 4'h0, 16'h0000);
    send_command(OP_SHR, 4'h0, 16'h0000);
    send_command(OP_WRITE, 4'hF, 16'hFC00);
    send_command(OP_DEC, 4'h0, 16'h0000);
    send_command(OP_SHL, 4'h0, 16'h0000);
    send_command(OP_WRITE, 4'h0, 16'h0201);
    send_command(OP_SHR, 4'h0, 16'h0000);
  endtask

  task automatic test_store_restore();
    // The logic outputs must not follow entry one until a restore.
    send_command(OP_WRITE_ENTRY, 4'h1, 16'hFFFF);
    send_command(OP_WRITE, 4'h0, 16'h0155);
    send_command(OP_STORE, 4'h0, 16'h0000);
    send_command(OP_WRITE_ENTRY, 4'hF, 16'hA5A5);
    send_command(OP_READ_ENTRY, 4'h0, 16'h0000);
    send_command(OP_READ_ENTRY, 4'hF, 16'h0000);
    send_command(OP_INC, 4'h0, 16'h0000);
    send_command(OP_RESTORE, 4'h0, 16'h0000);
    send_command(OP_WRITE_ENTRY, 4'h0, 16'hFFFF);
    send_command(OP_RESTORE, 4'h0, 16'h0000);
  endtask

  task automatic test_unused_ops();
    send_command(OP_READ_WIPER, 4'h0, 16'h0000);
    send_command(OP_RSVD_1, 4'hF, 16'hFFFF);
    send_command(OP_RSVD_5, 4'hF, 16'hFFFF);
    send_command(OP_RSVD_7, 4'hF, 16'hFFFF);
    send_command(OP_RSVD_D, 4'hF, 16'hFFFF);
    send_command(OP_RSVD_F, 4'hF, 16'hFFFF);
  endtask

  function automatic logic [3:0] pick_opcode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) return OP_INC;
    if (r < 28) return OP_DEC;
    if (r < 34) return OP_SHL;
    if (r < 40) return OP_SHR;
    if (r < 50) return OP_WRITE;
    if (r < 56) return OP_STORE;
    if (r < 68) return OP_WRITE_ENTRY;
    if (r < 74) return OP_RESTORE;
    if (r < 84) return OP_READ_ENTRY;
    if (r < 92) return OP_READ_WIPER;
    if (r < 95) return OP_NOP;
    case ($urandom_range(0, 4))
      0: return OP_RSVD_1;
      1: return OP_RSVD_5;
      2: return OP_RSVD_7;
      3: return OP_RSVD_D;
      default: return OP_RSVD_F;
    endcase
  endfunction

  // Random data, often with the wiper bits near either end of the range or at midscale.
  function automatic logic [15:0] pick_data();
    logic [15:0] d;
    d = 16'($urandom);
    case ($urandom_range(0, 9))
      0: d[WIPER_BITS-1:0] = '0;
      1: d[WIPER_BITS-1:0] = WIPER_FULL;
      2: d[WIPER_BITS-1:0] = WIPER_FULL - 1'b1;
      3: d[WIPER_BITS-1:0] = WIPER_MID;
      default: ;
    endcase
    return d;
  endfunction

  // Bursts of one opcode: runs of steps reach the saturation points.
  task automatic send_random_burst(ref int count);
    logic [3:0] op;
    int         run;
    op = pick_opcode();
    run = (op == OP_INC || op == OP_DEC || op == OP_SHL || op == OP_SHR) ?
          $urandom_range(1, 12) : 1;
    repeat (run) begin
      send_command(op, 4'($urandom), pick_data());
      count++;
    end
  endtask

  task automatic test_backpressure();
    int count;
    count = 0;
    hold_results = 1'b1;
    no_idle = 1'b1;
    while (count < 40) send_random_burst(count);
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    int count;
    count = 0;
    while (count < RANDOM_ITEMS) begin
      if (count % 200 < 12) no_idle = ($urandom_range(0, 3) == 0);
      send_random_burst(count);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    reset_pot_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_saturation();
    test_store_restore();
    test_unused_ops();
    test_backpressure();
    test_random();
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> digipot_command_engine_top.f
rtl/dcmd_pkg.sv
rtl/dcmd_in_stage.sv
rtl/dcmd_exec.sv
rtl/dcmd_out_stage.sv
rtl/digipot_command_engine_top.sv
rtl/dcmd_checker.sv
bench/tb.sv
